### hdl/sha_pkg.sv
package sha_pkg;

    localparam int WORD_W  = 32;
    localparam int ROUNDS  = 64;
    localparam int BLK_WORDS = 16;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_item;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } t_out_item;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_vec(input logic mode, input logic [2:0] i);
        logic [31:0] v;
        case ({mode, i})
            4'h0: v = 32'h6a09e667; 4'h1: v = 32'hbb67ae85; 4'h2: v = 32'h3c6ef372;
            4'h3: v = 32'ha54ff53a; 4'h4: v = 32'h510e527f; 4'h5: v = 32'h9b05688c;
            4'h6: v = 32'h1f83d9ab; 4'h7: v = 32'h5be0cd19; 4'h8: v = 32'hc1059ed8;
            4'h9: v = 32'h367cd507; 4'ha: v = 32'h3070dd17; 4'hb: v = 32'hf70e5939;
            4'hc: v = 32'hffc00b31; 4'hd: v = 32'h68581511; 4'he: v = 32'h64f98fa7;
            default: v = 32'hbefa4fa4;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### hdl/sha_round.sv
module sha_round (
    input  logic [sha_pkg::WORD_W*8-1:0] i_st,
    input  logic [31:0]                  i_w,
    input  logic [31:0]                  i_k,
    output logic [sha_pkg::WORD_W*8-1:0] o_st
);
    import sha_pkg::*;
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    always_comb begin
        {a, b, c, d, e, f, g, h} = i_st;
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + i_k + i_w;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        o_st = {t1 + t2, a, b, c, d + t1, e, f, g};
    end
endmodule

### hdl/sha_sched.sv
module sha_sched (
    input  logic [31:0] i_w16,
    input  logic [31:0] i_w15,
    input  logic [31:0] i_w7,
    input  logic [31:0] i_w2,
    output logic [31:0] o_w
);
    import sha_pkg::*;
    logic [31:0] s0, s1;
    always_comb begin
        s0  = rotr(i_w15, 7) ^ rotr(i_w15, 18) ^ (i_w15 >> 3);
        s1  = rotr(i_w2, 17) ^ rotr(i_w2, 19) ^ (i_w2 >> 10);
        o_w = i_w16 + s0 + i_w7 + s1;
    end
endmodule

### hdl/sha256_hash_engine_core.sv
// A word that does not fill a block is packed byte by byte, then the core returns to idle.
// A byte that fills the block starts a compression: 64 rounds and one final add.
// Last item: padding one byte per cycle plus one or two compressions, then
// 8 (SHA-256) or 7 (SHA-224) digest transactions, one per cycle when taken.
// The single shared round unit serves every compression; no new word is accepted until idle.
// Reset (i_rst_n low, synchronous): SHA-256 mode, initial vector, fill and length zero.
module sha256_hash_engine_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  sha_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output sha_pkg::t_out_item  o_data
);
    import sha_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_BYTE, S_PAD, S_LEN, S_COMP, S_FIN, S_OUT} t_state;

    t_state       r_state;
    logic         r_mode;
    logic [31:0]  r_hash [8];
    // Block buffer doubles as the message schedule window: shift one word per round.
    logic [31:0]  r_w [16];
    logic [5:0]   r_fill;
    logic [63:0]  r_len;
    logic [255:0] r_wk;        // working variables a..h
    logic [6:0]   r_rnd;       // round counter; 64 means final add
    logic [31:0]  r_data;
    logic [2:0]   r_left;      // bytes still to pack from the held word
    logic         r_last;
    logic         r_pad_done;  // 0x80 already written
    logic [2:0]   r_oidx;

    logic [255:0] rnd_out;
    logic [31:0]  w_new;
    logic [255:0] hash_flat;

    assign hash_flat = {r_hash[0], r_hash[1], r_hash[2], r_hash[3],
                        r_hash[4], r_hash[5], r_hash[6], r_hash[7]};

    sha_round u_round (.i_st(r_wk), .i_w(r_w[0]), .i_k(round_k(r_rnd[5:0])), .o_st(rnd_out));
    sha_sched u_sched (.i_w16(r_w[0]), .i_w15(r_w[1]), .i_w7(r_w[9]), .i_w2(r_w[14]),
                       .o_w(w_new));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data.digest_word = r_hash[r_oidx];
    assign o_data.last_word   = (r_oidx == (r_mode ? 3'd6 : 3'd7));

    // Write one byte at the fill position into the buffer.
    function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] pos,
                                        input logic [7:0] b);
        logic [31:0] m;
        m = w;
        m[(3 - pos) * 8 +: 8] = b;
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= 1'b0;
            r_fill  <= '0;
            r_len   <= '0;
            for (int i = 0; i < 8; i++) r_hash[i] <= init_vec(1'b0, 3'(i));
        end else if (i_cfg_we) begin
            // Abort any message and restart in the new mode.
            r_mode  <= i_cfg_wdata;
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_len   <= '0;
            for (int i = 0; i < 8; i++) r_hash[i] <= init_vec(i_cfg_wdata, 3'(i));
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_data     <= i_data.data_word;
                        r_left     <= (i_data.byte_count > 3'd4) ? 3'd4 : i_data.byte_count;
                        r_last     <= i_data.last_item;
                        r_pad_done <= 1'b0;
                        r_state    <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    if (r_left != 3'd0) begin
                        // Pack one message byte, advance the length.
                        r_w[r_fill[5:2]] <= put(r_w[r_fill[5:2]], r_fill[1:0], r_data[31:24]);
                        r_data <= r_data << 8;
                        r_left <= r_left - 3'd1;
                        r_len  <= r_len + 64'd8;
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_rnd   <= '0;
                            r_wk    <= hash_flat;
                            r_state <= S_COMP;
                        end
                    end else if (r_last) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    if (r_pad_done && r_fill == 6'd56) begin
                        r_state <= S_LEN;
                    end else begin
                        r_w[r_fill[5:2]] <= put(r_w[r_fill[5:2]], r_fill[1:0],
                                                r_pad_done ? 8'h00 : 8'h80);
                        r_pad_done <= 1'b1;
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_rnd   <= '0;
                            r_wk    <= hash_flat;
                            r_state <= S_COMP;
                        end
                    end
                end
                S_LEN: begin
                    r_w[14] <= r_len[63:32];
                    r_w[15] <= r_len[31:0];
                    r_fill  <= '0;
                    r_last  <= 1'b0;
                    r_rnd   <= '0;
                    r_wk    <= hash_flat;
                    r_state <= S_FIN;
                end
                S_COMP, S_FIN: begin
                    if (r_rnd == 7'd64) begin
                        for (int i = 0; i < 8; i++)
                            r_hash[i] <= r_hash[i] + r_wk[(7 - i) * 32 +: 32];
                        r_oidx <= '0;
                        if (r_state == S_FIN) r_state <= S_OUT;
                        else if (r_left != 3'd0 || r_last) r_state <= r_left != 3'd0 ? S_BYTE
                                                                                  : S_PAD;
                        else r_state <= S_IDLE;
                    end else begin
                        r_wk <= rnd_out;
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                        r_w[15] <= w_new;
                        r_rnd <= r_rnd + 7'd1;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (o_data.last_word) begin
                            r_len   <= '0;
                            r_state <= S_IDLE;
                            for (int i = 0; i < 8; i++) r_hash[i] <= init_vec(r_mode, 3'(i));
                        end
                        r_oidx <= r_oidx + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/sha_checker.sv
module sha_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input sha_pkg::t_out_item o_data
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while digest pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output changed");
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last_word |=> !o_valid) else $error("extra digest word");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready stayed after accept");
endmodule

bind sha256_hash_engine_core sha_checker u_chk (.*);

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int HOLD_CYCLES  = 600;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_data;

    sha256_hash_engine_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: mode, chaining words, block buffer, fill position, bit count.
    logic        sha224_sel;
    logic [31:0] chain_h [8];
    logic [31:0] blk_buf [16];
    logic [5:0]  blk_fill;
    logic [63:0] msg_bits;

    t_in_item  pending_words[$];
    t_out_item digest_q[$];
    int        fail_cnt = 0;
    int        cycle_cnt = 0;
    bit        quiet_phase = 1'b0;   // no idling on either side
    int        rx_hold = 0;          // long receiver hold-off, counted in the receiver
    int        hold_reqs = 0;        // hold-off requests raised by the stimulus
    int        hold_seen = 0;        // hold-off requests taken by the receiver
    bit        stim_done = 1'b0;

    // Handshake sampled at the last rising edge tells whether the held item was taken.
    logic o_ready_s = 1'b0;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] iv_word(logic m, int i);
        logic [31:0] iv256 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        logic [31:0] iv224 [8] = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
                                   32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
        return m ? iv224[i] : iv256[i];
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) chain_h[i] = iv_word(sha224_sel, i);
        blk_fill = '0;
        msg_bits = '0;
    endtask

    task automatic compress_blk();
        logic [31:0] kc [64] = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk_buf[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain_h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] += v[i];
    endtask

    task automatic push_byte(logic [7:0] b);
        blk_buf[blk_fill[5:2]][8*(3-blk_fill[1:0]) +: 8] = b;
        if (blk_fill == 6'd63) begin
            compress_blk();
            blk_fill = '0;
        end else begin
            blk_fill++;
        end
    endtask

    // Predict the digest words caused by one accepted transaction.
    task automatic predict_digest(t_in_item it);
        int nb;
        int nw;
        t_out_item r;
        nb = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
        for (int i = 0; i < nb; i++) begin
            push_byte(it.data_word[8*(3-i) +: 8]);
            msg_bits += 64'd8;
        end
        if (!it.last_item) return;
        push_byte(8'h80);
        while (blk_fill != 6'd56) push_byte(8'h00);
        blk_buf[14] = msg_bits[63:32];
        blk_buf[15] = msg_bits[31:0];
        compress_blk();
        nw = sha224_sel ? 7 : 8;
        for (int i = 0; i < nw; i++) begin
            r.digest_word = chain_h[i];
            r.last_word = (i == nw - 1);
            digest_q.push_back(r);
        end
        restart_hash();
    endtask

    // Driver: present queued words at the falling edge, idle at random.
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !o_ready_s)) begin
            if (pending_words.size() > 0 && (quiet_phase || $urandom_range(99) >= 34)) begin
                i_data  <= pending_words.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: accept on the rising edge, predict and check.
    always @(posedge i_clk) begin
        o_ready_s <= i_rst_n && i_valid && o_ready;
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_digest(i_data);
            end
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest transaction %h", o_data.digest_word);
                    fail_cnt++;
                end else begin
                    t_out_item e;
                    e = digest_q.pop_front();
                    if (e.digest_word !== o_data.digest_word) begin
                        $error("digest_word expected %h actual %h",
                               e.digest_word, o_data.digest_word);
                        fail_cnt++;
                    end
                    if (e.last_word !== o_data.last_word) begin
                        $error("last_word expected %b actual %b", e.last_word, o_data.last_word);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Receiver readiness at the falling edge; a long hold-off stalls the block.
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            rx_hold   <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet_phase || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("sha256_hash_engine_core test failed");
            $finish;
        end
    end

    task automatic add_word(logic [31:0] d, logic [2:0] c, logic l);
        t_in_item it;
        it.data_word = d;
        it.byte_count = c;
        it.last_item = l;
        pending_words.push_back(it);
    endtask

    // Random message: mostly whole words, a short tail, odd counts now and then.
    task automatic add_message(int nwords);
        logic [2:0] c;
        for (int i = 0; i < nwords; i++) begin
            c = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
            add_word($urandom, c, 1'b0);
        end
        add_word($urandom, 3'($urandom_range(7)), 1'b1);
    endtask

    task automatic drain_and_idle();
        while (pending_words.size() > 0 || i_valid || digest_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sha224_sel = m;
        restart_hash();
    endtask

    initial begin
        int sent;
        sha224_sel = 1'b0;
        for (int i = 0; i < 16; i++) blk_buf[i] = '0;
        restart_hash();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, "abc", extremes, oversize counts, partial mid words.
        add_word(32'h0, 3'd0, 1'b1);
        add_word(32'h61626300, 3'd3, 1'b1);
        add_word(32'hffffffff, 3'd4, 1'b0);
        add_word(32'h00000000, 3'd7, 1'b0);
        add_word(32'hffffffff, 3'd5, 1'b1);
        add_word(32'h12345678, 3'd1, 1'b0);
        add_word(32'h9abcdef0, 3'd2, 1'b0);
        add_word(32'hffffffff, 3'd6, 1'b1);
        for (int i = 0; i < 14; i++) add_word(32'ha5a5a5a5 ^ i, 3'd4, 1'b0);
        add_word(32'h5a5a5a5a, 3'd0, 1'b1);   // 56 bytes: padding takes a second block
        drain_and_idle();

        write_mode(1'b1);
        add_word(32'h61626300, 3'd3, 1'b1);
        add_word(32'h0, 3'd0, 1'b1);
        drain_and_idle();

        // Abort a message in progress with a mode write.
        add_word(32'hdeadbeef, 3'd4, 1'b0);
        drain_and_idle();
        write_mode(1'b0);

        // Pressure: hold the receiver off while several short messages flow in.
        hold_reqs++;
        for (int i = 0; i < 4; i++) add_message(1);
        drain_and_idle();

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 2) quiet_phase = 1'b1;
            if (ph == 3) quiet_phase = 1'b0;
            write_mode(ph[0]);
            while (sent < 60 * (ph + 1)) begin
                int n;
                n = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(18);
                add_message(n);
                sent += n + 1;
            end
            drain_and_idle();
        end

        if (fail_cnt == 0) begin
            $display("sha256_hash_engine_core test passed");
        end else begin
            $display("sha256_hash_engine_core test failed");
        end
        $finish;
    end
endmodule
